### hw/rtl/sfsp_pkg.sv
// Shared constants, register indexes and controller command type for the servo positioner.
`timescale 1ns / 1ps

package sfsp_pkg;

   // default sizing of the display bank
   localparam int DEF_MODULES     = 16;
   localparam int DEF_FLAPS       = 27;
   localparam int DEF_FLAP_COUNTS = 1000;

   // fixed field widths
   localparam int INDEX_W  = 4;
   localparam int LETTER_W = 5;
   localparam int HALL_W   = 12;
   localparam int VEL_W    = 10;
   localparam int PULSE_W  = 12;
   localparam int OUTPOS_W = 15;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_VELOCITY  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOME      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_PULSE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_PULSE = 3'd4;

   // register reset values
   localparam logic [VEL_W-1:0]    RST_VELOCITY  = 10'd49;
   localparam logic [HALL_W-1:0]   RST_TRIGGER   = 12'd2048;
   localparam logic [OUTPOS_W-1:0] RST_HOME      = 15'd0;
   localparam logic [PULSE_W-1:0]  RST_ON_PULSE  = 12'd256;
   localparam logic [PULSE_W-1:0]  RST_OFF_PULSE = 12'd0;

   // request kinds
   localparam logic REQ_LETTER = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request and read module state
      logic commit;    // write back module state and drive result beat
   } sfsp_cmd_type;

endpackage

### hw/rtl/sfsp_const_mod.sv
// Two-stage remainder by a constant divisor using a reciprocal multiply.
`timescale 1ns / 1ps

module sfsp_const_mod #(
   parameter int IN_W    = 15,
   parameter int DIVISOR = 27000,
   parameter int R_W     = 15
) (
   input  logic            clock,
   input  logic [IN_W-1:0] x,
   output logic [R_W-1:0]  r
);

   localparam int    L_W    = $clog2(DIVISOR);
   localparam int    SHIFT  = IN_W + L_W;
   localparam int    M_W    = IN_W + 2;
   localparam int    P_W    = IN_W + M_W;
   localparam int    D_W    = $clog2(DIVISOR + 1);
   localparam int    W      = IN_W + D_W;
   localparam longint M_VAL = ((64'(1) << SHIFT) + 64'(DIVISOR) - 64'(1)) / 64'(DIVISOR);
   localparam logic [M_W-1:0] RECIP = M_W'(M_VAL);

   logic [P_W-1:0]  prod;
   logic [IN_W-1:0] q_in, q_ff;
   logic [IN_W-1:0] x_ff;
   logic [W-1:0]    diff;
   logic [W-1:0]    rem;
   logic [R_W-1:0]  r_in, r_ff;

   // quotient estimate, exact for any IN_W-bit input
   assign prod = P_W'(x) * P_W'(RECIP);
   assign q_in = IN_W'(prod >> SHIFT);

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      x_ff <= x;
      r_ff <= r_in;
   end

   assign diff = W'(x_ff) - W'(q_ff) * W'(DIVISOR);

   always_comb begin
      rem = diff;
      if (diff >= W'(DIVISOR)) begin
         rem = diff - W'(DIVISOR);
      end
      r_in = R_W'(rem);
   end

   assign r = r_ff;

endmodule

### hw/rtl/sfsp_ctrl.sv
// Sequencing state machine: idle, state read, execute and write back.
`timescale 1ns / 1ps

module sfsp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output sfsp_pkg::sfsp_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### hw/rtl/sfsp_datapath.sv
// Datapath: config registers, per-module state memory, control step and result register.
`timescale 1ns / 1ps

module sfsp_datapath #(
   parameter int MODULES     = sfsp_pkg::DEF_MODULES,
   parameter int FLAPS       = sfsp_pkg::DEF_FLAPS,
   parameter int FLAP_COUNTS = sfsp_pkg::DEF_FLAP_COUNTS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sfsp_pkg::sfsp_cmd_type             cmd,
   input  logic                               req_type,
   input  logic [sfsp_pkg::INDEX_W-1:0]       req_module_index,
   input  logic [sfsp_pkg::LETTER_W-1:0]      req_letter,
   input  logic [sfsp_pkg::HALL_W-1:0]        req_hall_sample,
   input  logic                               csr_write_enable,
   input  logic [sfsp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sfsp_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output logic                               rsp_valid,
   output logic [sfsp_pkg::INDEX_W-1:0]       rsp_module_out,
   output logic                               rsp_servo_running,
   output logic                               rsp_pwm_write,
   output logic [sfsp_pkg::PULSE_W-1:0]       rsp_pulse_width,
   output logic [sfsp_pkg::OUTPOS_W-1:0]      rsp_position_estimate
);

   localparam int REV    = FLAPS * FLAP_COUNTS;
   localparam int WINDOW = FLAP_COUNTS / 4;
   localparam int POS_W  = $clog2(REV);
   localparam int AW     = (MODULES > 1) ? $clog2(MODULES) : 1;
   localparam int IDX_CW = 7;
   localparam int HW     = sfsp_pkg::HALL_W;

   // configuration registers
   logic [sfsp_pkg::VEL_W-1:0]    velocity_ff;
   logic [HW-1:0]                 trigger_ff;
   logic [sfsp_pkg::OUTPOS_W-1:0] home_ff;
   logic [sfsp_pkg::PULSE_W-1:0]  on_pulse_ff;
   logic [sfsp_pkg::PULSE_W-1:0]  off_pulse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_ff  <= sfsp_pkg::RST_VELOCITY;
         trigger_ff   <= sfsp_pkg::RST_TRIGGER;
         home_ff      <= sfsp_pkg::RST_HOME;
         on_pulse_ff  <= sfsp_pkg::RST_ON_PULSE;
         off_pulse_ff <= sfsp_pkg::RST_OFF_PULSE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sfsp_pkg::CSR_VELOCITY:  velocity_ff  <= csr_write_data[sfsp_pkg::VEL_W-1:0];
            sfsp_pkg::CSR_TRIGGER:   trigger_ff   <= csr_write_data[HW-1:0];
            sfsp_pkg::CSR_HOME:      home_ff      <= csr_write_data;
            sfsp_pkg::CSR_ON_PULSE:  on_pulse_ff  <= csr_write_data[sfsp_pkg::PULSE_W-1:0];
            sfsp_pkg::CSR_OFF_PULSE: off_pulse_ff <= csr_write_data[sfsp_pkg::PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   // home offset and velocity, each reduced into one revolution
   logic [POS_W-1:0] home_r;
   logic [POS_W-1:0] vel_r;

   sfsp_const_mod #(
      .IN_W    (sfsp_pkg::OUTPOS_W),
      .DIVISOR (REV),
      .R_W     (POS_W)
   ) u_home_mod (
      .clock (clock),
      .x     (home_ff),
      .r     (home_r)
   );

   sfsp_const_mod #(
      .IN_W    (sfsp_pkg::VEL_W),
      .DIVISOR (REV),
      .R_W     (POS_W)
   ) u_vel_mod (
      .clock (clock),
      .x     (velocity_ff),
      .r     (vel_r)
   );

   // captured request
   logic                          req_type_ff;
   logic [sfsp_pkg::INDEX_W-1:0]  req_index_ff;
   logic [sfsp_pkg::LETTER_W-1:0] req_letter_ff;
   logic [HW-1:0]                 req_hall_ff;

   // per-module state memory
   logic [POS_W-1:0] target_mem  [MODULES];
   logic [POS_W-1:0] wheel_mem   [MODULES];
   logic             running_mem [MODULES];
   logic [HW-1:0]    hall_mem    [MODULES];
   logic [MODULES-1:0] valid_ff;

   logic [POS_W-1:0] rd_target_ff;
   logic [POS_W-1:0] rd_wheel_ff;
   logic             rd_running_ff;
   logic [HW-1:0]    rd_hall_ff;
   logic             rd_valid_ff;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          out_of_range;

   assign rd_addr      = AW'(req_module_index);
   assign wr_addr      = AW'(req_index_ff);
   assign out_of_range = (IDX_CW'(req_index_ff) >= IDX_CW'(MODULES));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff   <= req_type;
         req_index_ff  <= req_module_index;
         req_letter_ff <= req_letter;
         req_hall_ff   <= req_hall_sample;
         rd_target_ff  <= target_mem[rd_addr];
         rd_wheel_ff   <= wheel_mem[rd_addr];
         rd_running_ff <= running_mem[rd_addr];
         rd_hall_ff    <= hall_mem[rd_addr];
         rd_valid_ff   <= valid_ff[rd_addr];
      end
   end

   // control step
   logic [POS_W-1:0]   cur_target, cur_wheel;
   logic               cur_running;
   logic [HW-1:0]      cur_hall;
   logic [IDX_CW-1:0]  letter_sat;
   logic [POS_W-1:0]   target_new;
   logic [POS_W:0]     window_top;
   logic               in_window;
   logic [POS_W:0]     adv_sum;
   logic [POS_W-1:0]   adv_pos;
   logic               home_edge;

   logic [POS_W-1:0]              nxt_target, nxt_wheel;
   logic                          nxt_running;
   logic [HW-1:0]                 nxt_hall;
   logic                          pwm;
   logic [sfsp_pkg::PULSE_W-1:0]  pulse;

   // entries not yet written read as the reset state
   assign cur_target  = rd_valid_ff ? rd_target_ff  : '0;
   assign cur_wheel   = rd_valid_ff ? rd_wheel_ff   : '0;
   assign cur_running = rd_valid_ff ? rd_running_ff : 1'b0;
   assign cur_hall    = rd_valid_ff ? rd_hall_ff    : '0;

   assign letter_sat = (IDX_CW'(req_letter_ff) >= IDX_CW'(FLAPS)) ?
                       IDX_CW'(FLAPS - 1) : IDX_CW'(req_letter_ff);
   assign target_new = POS_W'(32'(letter_sat) * FLAP_COUNTS);

   assign window_top = {1'b0, cur_target} + (POS_W + 1)'(WINDOW);
   assign in_window  = (cur_wheel >= cur_target) && ({1'b0, cur_wheel} < window_top);

   assign adv_sum = {1'b0, cur_wheel} + {1'b0, vel_r};
   assign adv_pos = (adv_sum >= (POS_W + 1)'(REV)) ?
                    POS_W'(adv_sum - (POS_W + 1)'(REV)) : POS_W'(adv_sum);

   // falling crossing of the trigger level
   assign home_edge = (cur_hall > trigger_ff) && (req_hall_ff < trigger_ff);

   always_comb begin
      nxt_target  = cur_target;
      nxt_wheel   = cur_wheel;
      nxt_running = cur_running;
      nxt_hall    = cur_hall;
      pwm         = 1'b0;
      pulse       = '0;
      if (req_type_ff == sfsp_pkg::REQ_LETTER) begin
         nxt_target = target_new;
      end else begin
         priority if (in_window) begin
            if (cur_running) begin
               pwm         = 1'b1;
               pulse       = off_pulse_ff;
               nxt_running = 1'b0;
            end
         end else if (!cur_running) begin
            pwm         = 1'b1;
            pulse       = on_pulse_ff;
            nxt_running = 1'b1;
         end else begin
            nxt_wheel = adv_pos;
         end
         if (home_edge) begin
            nxt_wheel = home_r;
         end
         nxt_hall = req_hall_ff;
      end
   end

   // write back
   always_ff @(posedge clock) begin
      if (cmd.commit && !out_of_range) begin
         target_mem[wr_addr]  <= nxt_target;
         wheel_mem[wr_addr]   <= nxt_wheel;
         running_mem[wr_addr] <= nxt_running;
         hall_mem[wr_addr]    <= nxt_hall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && !out_of_range) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // result register
   logic                          rsp_valid_ff;
   logic [sfsp_pkg::INDEX_W-1:0]  rsp_module_ff;
   logic                          rsp_running_ff;
   logic                          rsp_pwm_ff;
   logic [sfsp_pkg::PULSE_W-1:0]  rsp_pulse_ff;
   logic [sfsp_pkg::OUTPOS_W-1:0] rsp_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_module_ff  <= req_index_ff;
         rsp_running_ff <= out_of_range ? 1'b0 : nxt_running;
         rsp_pwm_ff     <= out_of_range ? 1'b0 : pwm;
         rsp_pulse_ff   <= out_of_range ? '0 : pulse;
         rsp_pos_ff     <= out_of_range ? '0 : sfsp_pkg::OUTPOS_W'(nxt_wheel);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_module_out        = rsp_module_ff;
   assign rsp_servo_running     = rsp_running_ff;
   assign rsp_pwm_write         = rsp_pwm_ff;
   assign rsp_pulse_width       = rsp_pulse_ff;
   assign rsp_position_estimate = rsp_pos_ff;

endmodule

### hw/rtl/split_flap_servo_positioner.sv
// Top level of the split-flap servo positioner: controller plus datapath.
// rsp_valid is high for one cycle; it is registered from the commit of the execute state.
// A new command is accepted only while idle; busy covers the state memory read cycle
//   and the execute cycle, which also lets the two-stage home/velocity reduction settle.
// Reset: synchronous, active high; config registers load defaults and all module
//   state reads as zero right away (per-entry valid bits are cleared by reset).
// The receiver cannot stall: each result beat is taken in the cycle it is shown.
`timescale 1ns / 1ps

module split_flap_servo_positioner #(
   parameter int MODULES     = sfsp_pkg::DEF_MODULES,
   parameter int FLAPS       = sfsp_pkg::DEF_FLAPS,
   parameter int FLAP_COUNTS = sfsp_pkg::DEF_FLAP_COUNTS
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [sfsp_pkg::INDEX_W-1:0]       req_module_index,
   input  logic [sfsp_pkg::LETTER_W-1:0]      req_letter,
   input  logic [sfsp_pkg::HALL_W-1:0]        req_hall_sample,
   // result channel
   output logic                               rsp_valid,
   output logic [sfsp_pkg::INDEX_W-1:0]       rsp_module_out,
   output logic                               rsp_servo_running,
   output logic                               rsp_pwm_write,
   output logic [sfsp_pkg::PULSE_W-1:0]       rsp_pulse_width,
   output logic [sfsp_pkg::OUTPOS_W-1:0]      rsp_position_estimate,
   // register write port
   input  logic                               csr_write_enable,
   input  logic [sfsp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sfsp_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   // capture on accept, commit from the execute state after the state read lands
   sfsp_pkg::sfsp_cmd_type cmd;

   sfsp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // per-module state lives in a small memory; one read-modify-write per command
   sfsp_datapath #(
      .MODULES     (MODULES),
      .FLAPS       (FLAPS),
      .FLAP_COUNTS (FLAP_COUNTS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_type              (req_type),
      .req_module_index      (req_module_index),
      .req_letter            (req_letter),
      .req_hall_sample       (req_hall_sample),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_module_out        (rsp_module_out),
      .rsp_servo_running     (rsp_servo_running),
      .rsp_pwm_write         (rsp_pwm_write),
      .rsp_pulse_width       (rsp_pulse_width),
      .rsp_position_estimate (rsp_position_estimate)
   );

endmodule

### verif/testbench.sv
// Self-checking testbench for the split-flap servo positioner: directed and random beats.
`timescale 1ns / 1ps

module testbench;

   // bank geometry, same as the block defaults
   localparam int MODULES    = sfsp_pkg::DEF_MODULES;
   localparam int FLAPS      = sfsp_pkg::DEF_FLAPS;
   localparam int FLAP_SPAN  = sfsp_pkg::DEF_FLAP_COUNTS;
   localparam int REV_COUNTS = FLAPS * FLAP_SPAN;
   localparam int STOP_SPAN  = FLAP_SPAN / 4;

   // register indexes past the end of the list; writes there must do nothing
   localparam logic [sfsp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [sfsp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                          kind;
      logic [sfsp_pkg::INDEX_W-1:0]  module_index;
      logic [sfsp_pkg::LETTER_W-1:0] letter;
      logic [sfsp_pkg::HALL_W-1:0]   hall;
   } servo_cmd_type;

   typedef struct packed {
      logic [sfsp_pkg::INDEX_W-1:0]  module_out;
      logic                          servo_running;
      logic                          pwm_write;
      logic [sfsp_pkg::PULSE_W-1:0]  pulse_width;
      logic [sfsp_pkg::OUTPOS_W-1:0] position_estimate;
   } servo_beat_type;

   // DUT hookup; every input known from time zero
   logic                             clock;
   logic                             reset            = 1'b1;
   logic                             start            = 1'b0;
   logic                             busy;
   logic                             req_type         = 1'b0;
   logic [sfsp_pkg::INDEX_W-1:0]     req_module_index = '0;
   logic [sfsp_pkg::LETTER_W-1:0]    req_letter       = '0;
   logic [sfsp_pkg::HALL_W-1:0]      req_hall_sample  = '0;
   logic                             rsp_valid;
   logic [sfsp_pkg::INDEX_W-1:0]     rsp_module_out;
   logic                             rsp_servo_running;
   logic                             rsp_pwm_write;
   logic [sfsp_pkg::PULSE_W-1:0]     rsp_pulse_width;
   logic [sfsp_pkg::OUTPOS_W-1:0]    rsp_position_estimate;
   logic                             csr_write_enable = 1'b0;
   logic [sfsp_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [sfsp_pkg::CSR_DATA_W-1:0]  csr_write_data   = '0;

   split_flap_servo_positioner dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_module_index      (req_module_index),
      .req_letter            (req_letter),
      .req_hall_sample       (req_hall_sample),
      .rsp_valid             (rsp_valid),
      .rsp_module_out        (rsp_module_out),
      .rsp_servo_running     (rsp_servo_running),
      .rsp_pwm_write         (rsp_pwm_write),
      .rsp_pulse_width       (rsp_pulse_width),
      .rsp_position_estimate (rsp_position_estimate),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // shadow copy of the register file
   logic [sfsp_pkg::VEL_W-1:0]    step_counts = sfsp_pkg::RST_VELOCITY;
   logic [sfsp_pkg::HALL_W-1:0]   home_level  = sfsp_pkg::RST_TRIGGER;
   logic [sfsp_pkg::OUTPOS_W-1:0] home_load   = sfsp_pkg::RST_HOME;
   logic [sfsp_pkg::PULSE_W-1:0]  run_width   = sfsp_pkg::RST_ON_PULSE;
   logic [sfsp_pkg::PULSE_W-1:0]  halt_width  = sfsp_pkg::RST_OFF_PULSE;

   // shadow copy of the per-module state, all zero out of reset
   logic [sfsp_pkg::OUTPOS_W-1:0] flap_target [MODULES];
   logic [sfsp_pkg::OUTPOS_W-1:0] wheel_count [MODULES];
   logic                          spinning    [MODULES];
   logic [sfsp_pkg::HALL_W-1:0]   last_hall   [MODULES];

   servo_cmd_type  pending_cmds[$];     // beats waiting to be offered on the command side
   servo_beat_type expected_beats[$];   // predicted result beats, oldest first
   int             send_idle_pct  = 0;  // chance per cycle that the sender holds off
   int             mismatch_count = 0;
   bit             cmd_taken      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // One command through the servo bank: updates the shadow state and
   // returns the beat the block must produce for it.
   function automatic servo_beat_type step_servo_bank(servo_cmd_type cmd);
      servo_beat_type beat;
      int unsigned pos;
      int unsigned tgt;
      int unsigned flap;
      int unsigned m;
      beat            = '0;
      m               = cmd.module_index;
      beat.module_out = cmd.module_index;
      if (cmd.kind == sfsp_pkg::REQ_LETTER) begin
         // letters past the last flap pin to the last flap
         flap = cmd.letter;
         if (flap >= FLAPS) flap = FLAPS - 1;
         flap_target[m] = sfsp_pkg::OUTPOS_W'(flap * FLAP_SPAN);
      end else begin
         pos = wheel_count[m];
         tgt = flap_target[m];
         if (pos >= tgt && pos < tgt + STOP_SPAN) begin
            // inside the stop window: halt a running servo
            if (spinning[m]) begin
               beat.pwm_write   = 1'b1;
               beat.pulse_width = halt_width;
               spinning[m]      = 1'b0;
            end
         end else if (!spinning[m]) begin
            beat.pwm_write   = 1'b1;
            beat.pulse_width = run_width;
            spinning[m]      = 1'b1;
         end else begin
            pos = (pos + step_counts) % REV_COUNTS;
         end
         // falling crossing of the trigger level re-homes the wheel
         if (last_hall[m] > home_level && cmd.hall < home_level)
            pos = home_load % REV_COUNTS;
         wheel_count[m] = sfsp_pkg::OUTPOS_W'(pos);
         last_hall[m]   = cmd.hall;
      end
      beat.servo_running     = spinning[m];
      beat.position_estimate = wheel_count[m];
      return beat;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         mismatch_count++;
      end
   endfunction

   // Command driver: holds a beat until it is taken, otherwise idles at random.
   always @(negedge clock) begin
      if (pending_cmds.size() != 0 &&
          ((start && !cmd_taken) || $urandom_range(99, 0) >= send_idle_pct)) begin
         start            <= 1'b1;
         req_type         <= pending_cmds[0].kind;
         req_module_index <= pending_cmds[0].module_index;
         req_letter       <= pending_cmds[0].letter;
         req_hall_sample  <= pending_cmds[0].hall;
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: checks result beats first, then predicts for a command taken at this edge.
   always @(posedge clock) begin
      servo_beat_type want;
      cmd_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_beats.size() == 0) begin
               $error("result beat for module %0d with nothing expected", rsp_module_out);
               mismatch_count++;
            end else begin
               want = expected_beats.pop_front();
               check_field("module_out", want.module_out, rsp_module_out);
               check_field("servo_running", want.servo_running, rsp_servo_running);
               check_field("pwm_write", want.pwm_write, rsp_pwm_write);
               check_field("pulse_width", want.pulse_width, rsp_pulse_width);
               check_field("position_estimate", want.position_estimate,
                           rsp_position_estimate);
            end
         end
         if (start && !busy) begin
            cmd_taken = 1'b1;
            expected_beats.push_back(step_servo_bank(pending_cmds.pop_front()));
         end
      end
   end

   task automatic queue_cmd(logic kind, int unsigned m, int unsigned flap, int unsigned hall);
      servo_cmd_type cmd;
      cmd.kind         = kind;
      cmd.module_index = sfsp_pkg::INDEX_W'(m);
      cmd.letter       = sfsp_pkg::LETTER_W'(flap);
      cmd.hall         = sfsp_pkg::HALL_W'(hall);
      pending_cmds.push_back(cmd);
   endtask

   // Hall samples sit mostly above the trigger so crossings are rare and the
   // wheels get far enough to reach their stop windows.
   function automatic int unsigned pick_hall();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 95 && home_level < 4095)
         return $urandom_range(4095, home_level + 1);
      if (roll < 97 && home_level > 0)
         return $urandom_range(home_level - 1, 0);
      return $urandom_range(4095, 0);
   endfunction

   task automatic queue_random_cmds(int count);
      int unsigned m;
      int unsigned flap;
      int unsigned home_flap;
      home_flap = (home_load % REV_COUNTS) / FLAP_SPAN;
      for (int n = 0; n < count; n++) begin
         // a few busy modules get most of the traffic
         m = ($urandom_range(3, 0) != 0) ? $urandom_range(3, 0) : $urandom_range(15, 0);
         // targets near home are reachable between re-homes
         if ($urandom_range(1, 0) != 0) begin
            flap = home_flap + $urandom_range(8, 0);
            if (flap > 31) flap = 31;
         end else begin
            flap = $urandom_range(31, 0);
         end
         if ($urandom_range(99, 0) < 12)
            queue_cmd(sfsp_pkg::REQ_LETTER, m, flap, $urandom_range(4095, 0));
         else
            queue_cmd(sfsp_pkg::REQ_TICK, m, flap, pick_hall());
      end
   endtask

   // Register writes happen only with nothing in flight, so the shadow
   // copy may change right away.
   task automatic write_reg(logic [sfsp_pkg::CSR_INDEX_W-1:0] idx,
                            logic [sfsp_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      unique case (idx)
         sfsp_pkg::CSR_VELOCITY:  step_counts = data[sfsp_pkg::VEL_W-1:0];
         sfsp_pkg::CSR_TRIGGER:   home_level  = data[sfsp_pkg::HALL_W-1:0];
         sfsp_pkg::CSR_HOME:      home_load   = data[sfsp_pkg::OUTPOS_W-1:0];
         sfsp_pkg::CSR_ON_PULSE:  run_width   = data[sfsp_pkg::PULSE_W-1:0];
         sfsp_pkg::CSR_OFF_PULSE: halt_width  = data[sfsp_pkg::PULSE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || expected_beats.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_regs(int vel, int trig, int home, int on_w, int off_w);
      write_reg(sfsp_pkg::CSR_VELOCITY, sfsp_pkg::CSR_DATA_W'(vel));
      write_reg(sfsp_pkg::CSR_TRIGGER, sfsp_pkg::CSR_DATA_W'(trig));
      write_reg(sfsp_pkg::CSR_HOME, sfsp_pkg::CSR_DATA_W'(home));
      write_reg(sfsp_pkg::CSR_ON_PULSE, sfsp_pkg::CSR_DATA_W'(on_w));
      write_reg(sfsp_pkg::CSR_OFF_PULSE, sfsp_pkg::CSR_DATA_W'(off_w));
   endtask

   initial begin
      for (int m = 0; m < MODULES; m++) begin
         flap_target[m] = '0;
         wheel_count[m] = '0;
         spinning[m]    = 1'b0;
         last_hall[m]   = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed beats, reset register values, no idling
      queue_cmd(sfsp_pkg::REQ_LETTER, 0, 0, 0);
      queue_cmd(sfsp_pkg::REQ_TICK, 0, 0, 0);          // in window, already stopped: no write
      queue_cmd(sfsp_pkg::REQ_LETTER, 15, 31, 4095);   // past last flap, pins to Z
      queue_cmd(sfsp_pkg::REQ_LETTER, 3, 27, 0);       // first letter past the last flap
      queue_cmd(sfsp_pkg::REQ_LETTER, 2, 26, 0);
      queue_cmd(sfsp_pkg::REQ_TICK, 15, 0, 4095);      // outside window: start
      queue_cmd(sfsp_pkg::REQ_TICK, 15, 0, 4095);      // running: advance
      queue_cmd(sfsp_pkg::REQ_TICK, 15, 0, 0);         // falling crossing re-homes
      queue_cmd(sfsp_pkg::REQ_TICK, 15, 0, 2048);      // at the level: no crossing
      queue_cmd(sfsp_pkg::REQ_TICK, 15, 0, 2049);
      queue_cmd(sfsp_pkg::REQ_TICK, 15, 0, 2048);      // from above to equal: no crossing
      queue_cmd(sfsp_pkg::REQ_TICK, 15, 0, 2049);
      queue_cmd(sfsp_pkg::REQ_TICK, 15, 0, 2047);      // just across
      queue_cmd(sfsp_pkg::REQ_LETTER, 1, 1, 0);
      queue_cmd(sfsp_pkg::REQ_TICK, 1, 0, 0);          // start
      queue_cmd(sfsp_pkg::REQ_TICK, 1, 0, 0);
      queue_cmd(sfsp_pkg::REQ_LETTER, 1, 0, 0);
      queue_cmd(sfsp_pkg::REQ_TICK, 1, 0, 100);        // back in window: stop
      queue_cmd(sfsp_pkg::REQ_TICK, 1, 0, 3000);
      queue_cmd(sfsp_pkg::REQ_TICK, 3, 21, 1234);
      queue_cmd(sfsp_pkg::REQ_TICK, 3, 10, 2730);
      queue_cmd(sfsp_pkg::REQ_TICK, 3, 0, 1365);
      queue_cmd(sfsp_pkg::REQ_LETTER, 8, 10, 2730);
      queue_cmd(sfsp_pkg::REQ_LETTER, 7, 21, 1365);
      wait_drained();

      // fast wheels, full-scale start width, no idling
      load_regs(240, 2048, 0, 4095, 0);
      send_idle_pct = 0;
      queue_random_cmds(450);
      wait_drained();

      // all-ones writes but for the start width: widest velocity, top trigger, home past one revolution
      load_regs(32'h7FFF, 32'h7FFF, 32'h7FFF, 0, 32'h7FFF);
      send_idle_pct = 77;
      queue_random_cmds(400);
      wait_drained();

      // zero velocity and a trigger that can never be crossed
      load_regs(0, 0, 26999, 1, 2);
      send_idle_pct = 0;
      queue_random_cmds(200);
      wait_drained();

      // mid-range settings; spare indexes must leave the registers alone
      load_regs(125, 3000, 12345, 2730, 1365);
      for (int i = CSR_SPARE_LO; i <= CSR_SPARE_HI; i++)
         write_reg(sfsp_pkg::CSR_INDEX_W'(i), '1);
      send_idle_pct = 10;
      queue_random_cmds(750);
      wait_drained();

      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
hw/rtl/sfsp_pkg.sv
hw/rtl/sfsp_const_mod.sv
hw/rtl/sfsp_ctrl.sv
hw/rtl/sfsp_datapath.sv
hw/rtl/split_flap_servo_positioner.sv
verif/testbench.sv
